@@ src/cse_pkg.sv @@
// Shared types and constants of the 6502 subset execute unit.
package cse_pkg;

  typedef enum logic [4:0] {
    OP_LDA = 5'd0,
    OP_LDX = 5'd1,
    OP_LDY = 5'd2,
    OP_STA = 5'd3,
    OP_STX = 5'd4,
    OP_STY = 5'd5,
    OP_TAX = 5'd6,
    OP_TAY = 5'd7,
    OP_TXA = 5'd8,
    OP_TYA = 5'd9,
    OP_TSX = 5'd10,
    OP_TXS = 5'd11,
    OP_AND = 5'd12,
    OP_ORA = 5'd13,
    OP_EOR = 5'd14,
    OP_INX = 5'd15,
    OP_DEX = 5'd16,
    OP_INY = 5'd17,
    OP_DEY = 5'd18,
    OP_INC = 5'd19,
    OP_DEC = 5'd20
  } op_e;

  typedef enum logic [2:0] {
    MODE_IMM = 3'd0,
    MODE_ACC = 3'd1,
    MODE_ABS = 3'd2,
    MODE_ZP  = 3'd3,
    MODE_ABX = 3'd4,
    MODE_ABY = 3'd5,
    MODE_ZPX = 3'd6,
    MODE_ZPY = 3'd7
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_ZP    = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    CLS_READ   = 2'd0,
    CLS_STORE  = 2'd1,
    CLS_INCDEC = 2'd2,
    CLS_REG    = 2'd3
  } class_e;

  typedef enum logic [1:0] {
    BK_CLEAR = 2'd0,
    BK_ADDR  = 2'd1,
    BK_EXEC  = 2'd2
  } back_state_e;

  // Decoded instruction as it travels from front to back.
  typedef struct packed {
    class_e      cls;
    op_e         op;
    mode_e       mode;
    logic [15:0] operand;
    logic        zp_err;
  } item_t;

  localparam int unsigned CALC_W = 17;  // operand plus an 8-bit index
  localparam int unsigned EA_W   = 11;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W = 1;
  localparam int unsigned QCNT_W = 2;

endpackage

@@ src/cse_if.sv @@
// Valid/ready channel interfaces for instructions and results.
interface cse_in_if;
  logic        valid;
  logic        ready;
  logic [4:0]  operation;
  logic [2:0]  addr_mode;
  logic [15:0] operand;

  modport source (output valid, output operation, output addr_mode, output operand,
                  input ready);
  modport sink (input valid, input operation, input addr_mode, input operand,
                output ready);
endinterface

interface cse_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  acc;
  logic [7:0]  index_x;
  logic [7:0]  index_y;
  logic [7:0]  stack_ptr;
  logic [10:0] eff_address;
  logic [7:0]  mem_byte;
  logic [1:0]  status;

  modport source (output valid, output acc, output index_x, output index_y,
                  output stack_ptr, output eff_address, output mem_byte,
                  output status, input ready);
  modport sink (input valid, input acc, input index_x, input index_y,
                input stack_ptr, input eff_address, input mem_byte,
                input status, output ready);
endinterface

@@ src/cse_front.sv @@
// Front end: accepts instructions and classifies them for the back end.
module cse_front (
  cse_in_if.sink         in_i,
  input  logic           q_ready_i,
  input  logic           mem_rdy_i,
  output logic           push_o,
  output cse_pkg::item_t item_o
);

  cse_pkg::op_e   op;
  cse_pkg::mode_e mode;

  assign op   = cse_pkg::op_e'(in_i.operation);
  assign mode = cse_pkg::mode_e'(in_i.addr_mode);

  assign in_i.ready = q_ready_i && mem_rdy_i;
  assign push_o     = in_i.valid && in_i.ready;

  always_comb begin
    item_o.op      = op;
    item_o.mode    = mode;
    item_o.operand = in_i.operand;
    item_o.zp_err  = (in_i.operand[15:8] != 8'd0) &&
                     (mode == cse_pkg::MODE_ZP || mode == cse_pkg::MODE_ZPX ||
                      mode == cse_pkg::MODE_ZPY);
    case (op)
      cse_pkg::OP_LDA, cse_pkg::OP_LDX, cse_pkg::OP_LDY,
      cse_pkg::OP_AND, cse_pkg::OP_ORA, cse_pkg::OP_EOR: item_o.cls = cse_pkg::CLS_READ;
      cse_pkg::OP_STA, cse_pkg::OP_STX, cse_pkg::OP_STY: item_o.cls = cse_pkg::CLS_STORE;
      cse_pkg::OP_INC, cse_pkg::OP_DEC:                  item_o.cls = cse_pkg::CLS_INCDEC;
      default:                                           item_o.cls = cse_pkg::CLS_REG;
    endcase
  end

endmodule

@@ src/cse_queue.sv @@
// Two-entry queue of decoded instructions between front and back.
module cse_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  cse_pkg::item_t item_i,
  output logic           ready_o,
  input  logic           pop_i,
  output logic           valid_o,
  output cse_pkg::item_t item_o
);

  cse_pkg::item_t                entry_q [cse_pkg::QUEUE_DEPTH];
  logic [cse_pkg::QPTR_W-1:0]    wr_ptr_q, wr_ptr_d;
  logic [cse_pkg::QPTR_W-1:0]    rd_ptr_q, rd_ptr_d;
  logic [cse_pkg::QCNT_W-1:0]    cnt_q, cnt_d;

  assign ready_o = cnt_q != cse_pkg::QCNT_W'(cse_pkg::QUEUE_DEPTH);
  assign valid_o = cnt_q != '0;
  assign item_o  = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

@@ src/cse_back.sv @@
// Back end: address resolution, data memory, register file and result register.
module cse_back #(
  parameter int unsigned MEM_DEPTH = 2048
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           q_valid_i,
  input  cse_pkg::item_t item_i,
  output logic           pop_o,
  output logic           mem_rdy_o,
  cse_out_if.source      out_o
);

  localparam int unsigned AW = $clog2(MEM_DEPTH);
  localparam logic [cse_pkg::CALC_W-1:0] DEPTH_C = cse_pkg::CALC_W'(MEM_DEPTH);
  localparam logic [AW-1:0] LAST_C = AW'(MEM_DEPTH - 1);

  cse_pkg::back_state_e state_q, state_d;

  logic [7:0] mem_q [MEM_DEPTH];
  logic [7:0] rd_q;
  logic [AW-1:0] clr_q;

  logic [7:0] a_q, a_d, x_q, x_d, y_q, y_d, sp_q, sp_d;

  // Execute-stage latch
  cse_pkg::item_t           ex_item_q;
  logic [AW-1:0]            ex_addr_q;
  logic [cse_pkg::EA_W-1:0] ex_ea_q;
  logic                     ex_access_q;
  cse_pkg::status_e         ex_status_q;

  // Address stage
  logic [cse_pkg::CALC_W-1:0] base, addr;
  logic [7:0]                 zp_x, zp_y;
  logic                       access;
  cse_pkg::status_e           status;

  // Execute stage
  logic                     out_free, fire, clearing, wr_en;
  logic [7:0]               src, rval, nval, wdata, mb;
  logic [cse_pkg::EA_W-1:0] ea;
  logic                     ok;

  logic                     mem_we;
  logic [AW-1:0]            mem_wa;
  logic [7:0]               mem_wd;

  // Result register
  logic                     ov_q;
  logic [7:0]               oa_q, ox_q, oy_q, osp_q, omb_q;
  logic [cse_pkg::EA_W-1:0] oea_q;
  cse_pkg::status_e         ost_q;

  // Address resolution with current X and Y
  always_comb begin
    base = {1'b0, item_i.operand};
    zp_x = item_i.operand[7:0] + x_q;
    zp_y = item_i.operand[7:0] + y_q;
    case (item_i.mode)
      cse_pkg::MODE_ABX: addr = base + {9'd0, x_q};
      cse_pkg::MODE_ABY: addr = base + {9'd0, y_q};
      cse_pkg::MODE_ZPX: addr = {9'd0, zp_x};
      cse_pkg::MODE_ZPY: addr = {9'd0, zp_y};
      default:           addr = base;
    endcase
    if (item_i.cls == cse_pkg::CLS_INCDEC) begin
      addr = base;
    end
    access = (item_i.cls == cse_pkg::CLS_READ && item_i.mode != cse_pkg::MODE_IMM &&
              item_i.mode != cse_pkg::MODE_ACC) ||
             (item_i.cls == cse_pkg::CLS_STORE && item_i.mode != cse_pkg::MODE_ACC) ||
             (item_i.cls == cse_pkg::CLS_INCDEC);
    if (!access) begin
      status = cse_pkg::ST_OK;
    end else if (item_i.cls != cse_pkg::CLS_INCDEC && item_i.zp_err) begin
      status = cse_pkg::ST_ZP;
    end else if (addr >= DEPTH_C) begin
      status = cse_pkg::ST_RANGE;
    end else begin
      status = cse_pkg::ST_OK;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      cse_pkg::BK_CLEAR: begin
        if (clr_q == LAST_C) state_d = cse_pkg::BK_ADDR;
      end
      cse_pkg::BK_ADDR: begin
        if (q_valid_i) state_d = cse_pkg::BK_EXEC;
      end
      cse_pkg::BK_EXEC: begin
        if (out_free) state_d = cse_pkg::BK_ADDR;
      end
      default: state_d = cse_pkg::BK_CLEAR;
    endcase
  end

  // State outputs
  always_comb begin
    out_free  = !ov_q || out_o.ready;
    pop_o     = 1'b0;
    fire      = 1'b0;
    clearing  = 1'b0;
    mem_rdy_o = 1'b1;
    case (state_q)
      cse_pkg::BK_CLEAR: begin
        clearing  = 1'b1;
        mem_rdy_o = 1'b0;
      end
      cse_pkg::BK_ADDR: pop_o = q_valid_i;
      cse_pkg::BK_EXEC: fire = out_free;
      default: mem_rdy_o = 1'b0;
    endcase
  end

  // Execute
  always_comb begin
    ok = ex_status_q == cse_pkg::ST_OK;
    case (ex_item_q.op)
      cse_pkg::OP_STA: src = a_q;
      cse_pkg::OP_STX: src = x_q;
      default:         src = y_q;
    endcase
    case (ex_item_q.mode)
      cse_pkg::MODE_IMM: rval = ex_item_q.operand[7:0];
      cse_pkg::MODE_ACC: rval = a_q;
      default:           rval = rd_q;
    endcase
    nval  = (ex_item_q.op == cse_pkg::OP_INC) ? rd_q + 8'd1 : rd_q - 8'd1;
    a_d   = a_q;
    x_d   = x_q;
    y_d   = y_q;
    sp_d  = sp_q;
    wr_en = 1'b0;
    wdata = src;
    mb    = '0;
    ea    = '0;
    case (ex_item_q.cls)
      cse_pkg::CLS_READ: begin
        if (ok) begin
          case (ex_item_q.op)
            cse_pkg::OP_LDA: a_d = rval;
            cse_pkg::OP_LDX: x_d = rval;
            cse_pkg::OP_LDY: y_d = rval;
            cse_pkg::OP_AND: a_d = a_q & rval;
            cse_pkg::OP_ORA: a_d = a_q | rval;
            default:         a_d = a_q ^ rval;
          endcase
          if (ex_access_q) begin
            mb = rval;
            ea = ex_ea_q;
          end
        end
      end
      cse_pkg::CLS_STORE: begin
        if (ex_item_q.mode == cse_pkg::MODE_ACC) begin
          a_d = src;
        end else if (ok) begin
          wr_en = 1'b1;
          mb    = src;
          ea    = ex_ea_q;
        end
      end
      cse_pkg::CLS_INCDEC: begin
        if (ok) begin
          wr_en = 1'b1;
          wdata = nval;
          mb    = nval;
          ea    = ex_ea_q;
        end
      end
      default: begin
        case (ex_item_q.op)
          cse_pkg::OP_TAX: x_d  = a_q;
          cse_pkg::OP_TAY: y_d  = a_q;
          cse_pkg::OP_TXA: a_d  = x_q;
          cse_pkg::OP_TYA: a_d  = y_q;
          cse_pkg::OP_TSX: x_d  = sp_q;
          cse_pkg::OP_TXS: sp_d = x_q;
          cse_pkg::OP_INX: x_d  = x_q + 8'd1;
          cse_pkg::OP_DEX: x_d  = x_q - 8'd1;
          cse_pkg::OP_INY: y_d  = y_q + 8'd1;
          cse_pkg::OP_DEY: y_d  = y_q - 8'd1;
          default: ;
        endcase
      end
    endcase
  end

  assign mem_we = clearing || (fire && wr_en);
  assign mem_wa = clearing ? clr_q : ex_addr_q;
  assign mem_wd = clearing ? 8'd0 : wdata;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_wa] <= mem_wd;
    end
    if (pop_o) begin
      rd_q <= mem_q[addr[AW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cse_pkg::BK_CLEAR;
      clr_q   <= '0;
      a_q     <= '0;
      x_q     <= '0;
      y_q     <= '0;
      sp_q    <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (clearing) clr_q <= clr_q + 1'b1;
      if (fire) begin
        a_q  <= a_d;
        x_q  <= x_d;
        y_q  <= y_d;
        sp_q <= sp_d;
        ov_q <= 1'b1;
      end else if (out_o.ready) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      ex_item_q   <= item_i;
      ex_addr_q   <= addr[AW-1:0];
      ex_ea_q     <= addr[cse_pkg::EA_W-1:0];
      ex_access_q <= access;
      ex_status_q <= status;
    end
    if (fire) begin
      oa_q  <= a_d;
      ox_q  <= x_d;
      oy_q  <= y_d;
      osp_q <= sp_d;
      omb_q <= mb;
      oea_q <= ea;
      ost_q <= ex_status_q;
    end
  end

  assign out_o.valid       = ov_q;
  assign out_o.acc         = oa_q;
  assign out_o.index_x     = ox_q;
  assign out_o.index_y     = oy_q;
  assign out_o.stack_ptr   = osp_q;
  assign out_o.eff_address = oea_q;
  assign out_o.mem_byte    = omb_q;
  assign out_o.status      = ost_q;

endmodule

@@ src/cpu6502_subset_execute_unit.sv @@
// Top level of the flagless 6502 subset execute unit.
//
// Executes one instruction per item and returns one result per item with A, X, Y,
// SP, the memory address touched, the byte moved and a status code. After reset the
// unit clears its MEM_DEPTH-byte data memory one byte per cycle, so no instruction
// is taken until the clear is done. A two-entry queue sits between the decoding
// front end and the execution back end; the back end handles each instruction in
// two steps (address and memory read, then execute and write-back on the single
// ported data memory) and takes no new item until the last has executed. When the
// back end is idle and the output is free, an accepted item passes through a queue
// entry and the execute-stage latch into the result register, where it goes valid.
module cpu6502_subset_execute_unit #(
  parameter int unsigned MEM_DEPTH = 2048
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  cse_in_if.sink    in_i,
  cse_out_if.source out_o
);

  logic           push, q_ready, q_valid, pop, mem_rdy;
  cse_pkg::item_t push_item, pop_item;

  cse_front u_front (
    .in_i      (in_i),
    .q_ready_i (q_ready),
    .mem_rdy_i (mem_rdy),
    .push_o    (push),
    .item_o    (push_item)
  );

  cse_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .ready_o (q_ready),
    .pop_i   (pop),
    .valid_o (q_valid),
    .item_o  (pop_item)
  );

  cse_back #(
    .MEM_DEPTH (MEM_DEPTH)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .item_i    (pop_item),
    .pop_o     (pop),
    .mem_rdy_o (mem_rdy),
    .out_o     (out_o)
  );

endmodule

@@ sim/cse_result_checker.sv @@
// Execute-unit checker: predicts each instruction's outcome and compares returned results.
`timescale 1ns / 1ps

module cse_result_checker #(
  parameter int unsigned MEM_DEPTH = 2048
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  cse_in_if           in_mon_i,
  cse_out_if          out_mon_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  typedef struct packed {
    logic [7:0]        acc;
    logic [7:0]        ix;
    logic [7:0]        iy;
    logic [7:0]        sp;
    logic [10:0]       ea;
    logic [7:0]        mb;
    cse_pkg::status_e  st;
  } exec_result_t;

  logic [7:0]   acc_m;
  logic [7:0]   x_m;
  logic [7:0]   y_m;
  logic [7:0]   sp_m;
  logic [7:0]   mem_m [MEM_DEPTH];
  exec_result_t due_results [$];
  exec_result_t want;
  int unsigned  fails = 0;

  function automatic cse_pkg::status_e resolve_addr(input logic [2:0] mode,
                                                    input logic [15:0] opnd,
                                                    output logic [16:0] addr);
    logic [16:0] a;
    logic        zp;
    zp = (mode == cse_pkg::MODE_ZP) || (mode == cse_pkg::MODE_ZPX) ||
         (mode == cse_pkg::MODE_ZPY);
    case (mode)
      cse_pkg::MODE_ABX: a = {1'b0, opnd} + {9'd0, x_m};
      cse_pkg::MODE_ABY: a = {1'b0, opnd} + {9'd0, y_m};
      // zero-page indexing wraps within the page
      cse_pkg::MODE_ZPX: a = {9'd0, opnd[7:0] + x_m};
      cse_pkg::MODE_ZPY: a = {9'd0, opnd[7:0] + y_m};
      default:           a = {1'b0, opnd};
    endcase
    addr = a;
    if (zp && opnd > 16'd255) return cse_pkg::ST_ZP;
    if (a >= MEM_DEPTH) return cse_pkg::ST_RANGE;
    return cse_pkg::ST_OK;
  endfunction

  function automatic exec_result_t execute_insn(input logic [4:0] op, input logic [2:0] mode,
                                                input logic [15:0] opnd);
    exec_result_t     r;
    logic [16:0]      addr;
    logic [7:0]       val;
    cse_pkg::status_e st;
    r    = '0;
    addr = '0;
    val  = '0;
    st   = cse_pkg::ST_OK;
    case (op)
      cse_pkg::OP_LDA, cse_pkg::OP_LDX, cse_pkg::OP_LDY,
      cse_pkg::OP_AND, cse_pkg::OP_ORA, cse_pkg::OP_EOR: begin
        if (mode == cse_pkg::MODE_IMM) begin
          val = opnd[7:0];
        end else if (mode == cse_pkg::MODE_ACC) begin
          val = acc_m;
        end else begin
          st = resolve_addr(mode, opnd, addr);
          if (st == cse_pkg::ST_OK) begin
            val  = mem_m[addr];
            r.ea = addr[10:0];
            r.mb = val;
          end
        end
        if (st == cse_pkg::ST_OK) begin
          case (op)
            cse_pkg::OP_LDA: acc_m = val;
            cse_pkg::OP_LDX: x_m   = val;
            cse_pkg::OP_LDY: y_m   = val;
            cse_pkg::OP_AND: acc_m = acc_m & val;
            cse_pkg::OP_ORA: acc_m = acc_m | val;
            default:         acc_m = acc_m ^ val;
          endcase
        end
      end
      cse_pkg::OP_STA, cse_pkg::OP_STX, cse_pkg::OP_STY: begin
        val = (op == cse_pkg::OP_STA) ? acc_m : (op == cse_pkg::OP_STX) ? x_m : y_m;
        if (mode == cse_pkg::MODE_ACC) begin
          acc_m = val;
        end else begin
          st = resolve_addr(mode, opnd, addr);
          if (st == cse_pkg::ST_OK) begin
            mem_m[addr] = val;
            r.ea = addr[10:0];
            r.mb = val;
          end
        end
      end
      cse_pkg::OP_INC, cse_pkg::OP_DEC: begin
        // always absolute on the raw operand, whatever the mode
        if (opnd >= MEM_DEPTH) begin
          st = cse_pkg::ST_RANGE;
        end else begin
          val = (op == cse_pkg::OP_INC) ? mem_m[opnd] + 8'd1 : mem_m[opnd] - 8'd1;
          mem_m[opnd] = val;
          r.ea = opnd[10:0];
          r.mb = val;
        end
      end
      cse_pkg::OP_TAX: x_m   = acc_m;
      cse_pkg::OP_TAY: y_m   = acc_m;
      cse_pkg::OP_TXA: acc_m = x_m;
      cse_pkg::OP_TYA: acc_m = y_m;
      cse_pkg::OP_TSX: x_m   = sp_m;
      cse_pkg::OP_TXS: sp_m  = x_m;
      cse_pkg::OP_INX: x_m   = x_m + 8'd1;
      cse_pkg::OP_DEX: x_m   = x_m - 8'd1;
      cse_pkg::OP_INY: y_m   = y_m + 8'd1;
      cse_pkg::OP_DEY: y_m   = y_m - 8'd1;
      default: ;
    endcase
    r.acc = acc_m;
    r.ix  = x_m;
    r.iy  = y_m;
    r.sp  = sp_m;
    r.st  = st;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned exp_val);
    $display("chk: %0t %s: got %0h, want %0h", $realtime, what, got, exp_val);
    fails++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_m = '0;
      x_m   = '0;
      y_m   = '0;
      sp_m  = '0;
      for (int i = 0; i < MEM_DEPTH; i++) mem_m[i] = '0;
      pending_o    <= 0;
      fail_count_o <= 0;
    end else begin
      // retire first: a result never belongs to an item taken at the same edge
      if (out_mon_i.valid && out_mon_i.ready) begin
        if (due_results.size() == 0) begin
          report_mismatch("result with no item outstanding", 0, 0);
        end else begin
          want = due_results.pop_front();
          if (out_mon_i.acc !== want.acc) report_mismatch("acc", out_mon_i.acc, want.acc);
          if (out_mon_i.index_x !== want.ix) begin
            report_mismatch("index_x", out_mon_i.index_x, want.ix);
          end
          if (out_mon_i.index_y !== want.iy) begin
            report_mismatch("index_y", out_mon_i.index_y, want.iy);
          end
          if (out_mon_i.stack_ptr !== want.sp) begin
            report_mismatch("stack_ptr", out_mon_i.stack_ptr, want.sp);
          end
          if (out_mon_i.eff_address !== want.ea) begin
            report_mismatch("eff_address", out_mon_i.eff_address, want.ea);
          end
          if (out_mon_i.mem_byte !== want.mb) begin
            report_mismatch("mem_byte", out_mon_i.mem_byte, want.mb);
          end
          if (out_mon_i.status !== want.st) begin
            report_mismatch("status", out_mon_i.status, want.st);
          end
        end
      end
      if (in_mon_i.valid && in_mon_i.ready) begin
        due_results.insert(due_results.size(),
                           execute_insn(in_mon_i.operation, in_mon_i.addr_mode,
                                        in_mon_i.operand));
      end
      pending_o    <= due_results.size();
      fail_count_o <= fails;
    end
  end

endmodule

@@ sim/tb.sv @@
// Testbench top: drives instructions into the execute unit and reports the verdict.
`timescale 1ns / 1ps

module tb;

  localparam int unsigned MEM_DEPTH   = 2048;
  localparam int unsigned RAND_ITEMS  = 800;
  localparam int unsigned QUIET_ITEMS = 100;
  localparam logic [4:0]  OP_CODE_MAX = 5'd31;

  logic        clk_i  = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid  = 1'b0;
  logic [4:0]  in_op     = '0;
  logic [2:0]  in_mode   = '0;
  logic [15:0] in_opnd   = '0;
  logic        res_ready = 1'b0;
  logic        idle_en   = 1'b1;
  int unsigned stall_left = 0;
  int unsigned fail_count;
  int unsigned pending;

  cse_in_if  in_bus ();
  cse_out_if out_bus ();

  assign in_bus.valid     = in_valid;
  assign in_bus.operation = in_op;
  assign in_bus.addr_mode = in_mode;
  assign in_bus.operand   = in_opnd;
  assign out_bus.ready    = res_ready;

  cpu6502_subset_execute_unit #(
    .MEM_DEPTH(MEM_DEPTH)
  ) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_bus),
    .out_o (out_bus)
  );

  cse_result_checker #(
    .MEM_DEPTH(MEM_DEPTH)
  ) i_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_mon_i    (in_bus),
    .out_mon_i   (out_bus),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("tb: FAIL");
    $finish;
  end

  // result side: random stall bursts while idling is on
  always @(negedge clk_i) begin
    if (!idle_en) begin
      res_ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      res_ready  <= 1'b0;
    end else if ($urandom_range(0, 3) == 0) begin
      stall_left <= $urandom_range(0, 7);
      res_ready  <= 1'b0;
    end else begin
      res_ready <= 1'b1;
    end
  end

  // Called at a falling edge; returns at the falling edge after the item is taken.
  task automatic issue_insn(input logic [4:0] op, input logic [2:0] mode,
                            input logic [15:0] opnd);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk_i);
    end
    in_valid <= 1'b1;
    in_op    <= op;
    in_mode  <= mode;
    in_opnd  <= opnd;
    do @(posedge clk_i); while (!in_bus.ready);
    @(negedge clk_i);
  endtask

  // Bias toward a few small windows so memory locations get reused.
  function automatic logic [15:0] pick_operand();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 40) return 16'($urandom_range(0, 63));
    if (r < 55) return 16'($urandom_range(MEM_DEPTH - 64, MEM_DEPTH - 1));
    if (r < 70) return 16'($urandom_range(0, 255));
    if (r < 85) return 16'($urandom_range(0, MEM_DEPTH - 1));
    return 16'($urandom());
  endfunction

  initial begin
    logic [4:0] op;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // index wrap from zero in both directions
    issue_insn(cse_pkg::OP_DEX, cse_pkg::MODE_IMM, 16'h0000);
    issue_insn(cse_pkg::OP_INX, cse_pkg::MODE_ACC, 16'hFFFF);
    // immediate takes only the low byte
    issue_insn(cse_pkg::OP_LDA, cse_pkg::MODE_IMM, 16'hABFF);
    issue_insn(cse_pkg::OP_STA, cse_pkg::MODE_ABS, 16'(MEM_DEPTH - 1));
    issue_insn(cse_pkg::OP_LDX, cse_pkg::MODE_IMM, 16'h0010);
    // zero-page X wraps to the low page
    issue_insn(cse_pkg::OP_LDA, cse_pkg::MODE_ZPX, 16'h00FF);
    issue_insn(cse_pkg::OP_LDY, cse_pkg::MODE_ABS, 16'(MEM_DEPTH - 1));
    issue_insn(cse_pkg::OP_STX, cse_pkg::MODE_ABY, 16'h0700);
    issue_insn(cse_pkg::OP_INY, cse_pkg::MODE_IMM, 16'h0000);
    issue_insn(cse_pkg::OP_DEY, cse_pkg::MODE_IMM, 16'h0000);
    // indexed address one past the end of memory
    issue_insn(cse_pkg::OP_LDA, cse_pkg::MODE_ABX, 16'(MEM_DEPTH - 16));
    issue_insn(cse_pkg::OP_LDA, cse_pkg::MODE_ZP, 16'h0100);
    issue_insn(cse_pkg::OP_STY, cse_pkg::MODE_ZPY, 16'hFFFF);
    // accumulator-mode stores copy into A
    issue_insn(cse_pkg::OP_STA, cse_pkg::MODE_ACC, 16'h0000);
    issue_insn(cse_pkg::OP_STX, cse_pkg::MODE_ACC, 16'h0000);
    issue_insn(cse_pkg::OP_INC, cse_pkg::MODE_ZP, 16'h0000);
    issue_insn(cse_pkg::OP_DEC, cse_pkg::MODE_IMM, 16'h0001);
    issue_insn(cse_pkg::OP_INC, cse_pkg::MODE_ABS, 16'(MEM_DEPTH));
    issue_insn(cse_pkg::OP_STY, cse_pkg::MODE_IMM, 16'hFFFF);
    issue_insn(cse_pkg::OP_TXS, cse_pkg::MODE_IMM, 16'h0000);
    issue_insn(cse_pkg::OP_TSX, cse_pkg::MODE_IMM, 16'h0000);
    issue_insn(cse_pkg::OP_TAY, cse_pkg::MODE_IMM, 16'h0000);
    issue_insn(cse_pkg::OP_AND, cse_pkg::MODE_IMM, 16'h000F);
    issue_insn(cse_pkg::OP_ORA, cse_pkg::MODE_ZP, 16'h0001);
    issue_insn(cse_pkg::OP_EOR, cse_pkg::MODE_ACC, 16'h0000);
    issue_insn(cse_pkg::OP_TYA, cse_pkg::MODE_IMM, 16'h0000);
    issue_insn(cse_pkg::OP_TAX, cse_pkg::MODE_IMM, 16'h0000);
    issue_insn(cse_pkg::OP_TXA, cse_pkg::MODE_IMM, 16'h0000);
    issue_insn(OP_CODE_MAX, cse_pkg::MODE_ZPY, 16'hFFFF);

    for (int unsigned n = 0; n < RAND_ITEMS; n++) begin
      if (n == RAND_ITEMS - QUIET_ITEMS) idle_en <= 1'b0;
      if ($urandom_range(0, 99) < 8) begin
        op = 5'($urandom_range(cse_pkg::OP_DEC + 1, OP_CODE_MAX));
      end else begin
        op = 5'($urandom_range(cse_pkg::OP_LDA, cse_pkg::OP_DEC));
      end
      issue_insn(op, 3'($urandom_range(0, 7)), pick_operand());
    end
    in_valid <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

@@ files.f @@
src/cse_pkg.sv
src/cse_if.sv
src/cse_front.sv
src/cse_queue.sv
src/cse_back.sv
src/cpu6502_subset_execute_unit.sv
sim/cse_result_checker.sv
sim/tb.sv
